@@ design/maf_pkg.sv @@
`timescale 1ns / 1ps

package maf_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int WINDOW_RESET = 16;
  localparam int POS_BITS     = $clog2(WINDOW_MAX);
  localparam int COUNT_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(WINDOW_MAX);

  // action codes
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample;
  } req_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic        [COUNT_BITS-1:0]  fill_count;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

@@ design/moving_average_filter.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake          word
// req      in         req_valid/stall    action, sample
// rsp      out        rsp_valid/stall    average, fill_count
// cfg      in         cfg_valid/ready    window_size (7 bits)
//
// Push: the sequencer steps through idle, update, start, wait and done, and
// sits in wait for the 22 steps of the one-bit-a-cycle restoring divider.
// Clear: idle, then straight to done.
// rst is synchronous: window 16, filter empty, no result pending.
// rsp is registered, so a new word is taken while a result waits; that word
// holds in its last step until rsp frees up.
// cfg is taken only while the sequencer is idle.

module moving_average_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  maf_pkg::req_word_t                   req_word,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output maf_pkg::rsp_word_t                   rsp_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [maf_pkg::COUNT_BITS-1:0]       cfg_data
);
  import maf_pkg::*;

  state_t state, state_next;

  // filter state
  logic        [COUNT_BITS-1:0]  window_size;
  logic        [POS_BITS-1:0]    write_position;
  logic        [COUNT_BITS-1:0]  held_count;
  logic signed [SUM_BITS-1:0]    running_sum;

  // per-word working registers
  logic signed [SAMPLE_BITS-1:0] smp;
  logic        [POS_BITS-1:0]    pos;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic signed [SAMPLE_BITS-1:0] res_avg;

  // ring store, one write and one registered read port
  logic signed [SAMPLE_BITS-1:0] sample_store [WINDOW_MAX];

  logic                          req_take;
  logic                          cfg_take;
  logic                          rsp_free;
  logic                          div_start;
  logic                          div_done;
  logic signed [SUM_BITS-1:0]    div_quo;
  logic        [COUNT_BITS-1:0]  window_sat;
  logic        [POS_BITS-1:0]    pos_eff;
  logic        [COUNT_BITS-1:0]  pos_inc;
  logic        [POS_BITS-1:0]    pos_wrap;
  logic                          full;
  logic signed [SUM_BITS-1:0]    sum_next;
  logic        [COUNT_BITS-1:0]  count_next;

  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // saturate the window to 1..WINDOW_MAX
  always_comb begin
    priority if (cfg_data == '0) begin
      window_sat = COUNT_BITS'(1);
    end else if (cfg_data > COUNT_BITS'(WINDOW_MAX)) begin
      window_sat = COUNT_BITS'(WINDOW_MAX);
    end else begin
      window_sat = cfg_data;
    end
  end

  assign pos_eff  = (COUNT_BITS'(write_position) >= window_size) ? '0 : write_position;
  assign pos_inc  = COUNT_BITS'(pos) + 1'b1;
  assign pos_wrap = (pos_inc >= window_size) ? '0 : pos_inc[POS_BITS-1:0];

  // once full, the oldest sample leaves the sum as the new one arrives
  assign full       = (held_count >= window_size);
  assign count_next = full ? held_count : held_count + 1'b1;
  assign sum_next   = running_sum + SUM_BITS'(smp)
                    - (full ? SUM_BITS'(old_smp) : SUM_BITS'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = (req_word.action == ACT_CLEAR) ? ST_DONE : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_START;
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= COUNT_BITS'(WINDOW_RESET > WINDOW_MAX ? WINDOW_MAX : WINDOW_RESET);
      write_position <= '0;
      held_count     <= '0;
      running_sum    <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_take) begin
        window_size <= window_sat;
      end
      // a window write and a clear word both empty the filter
      if (cfg_take || (req_take && req_word.action == ACT_CLEAR)) begin
        write_position <= '0;
        held_count     <= '0;
        running_sum    <= '0;
      end else if (state == ST_UPDATE) begin
        held_count     <= count_next;
        running_sum    <= sum_next;
        write_position <= pos_wrap;
      end
      if (state == ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      smp     <= req_word.sample;
      pos     <= pos_eff;
      res_avg <= '0;
    end
    if (state == ST_WAIT && div_done) begin
      res_avg <= div_quo[SAMPLE_BITS-1:0];
    end
    if (state == ST_DONE && rsp_free) begin
      rsp_word.average    <= res_avg;
      rsp_word.fill_count <= held_count;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      sample_store[pos] <= smp;
    end
    if (req_take) begin
      old_smp <= sample_store[pos_eff];
    end
  end

  maf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (held_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    held_count <= window_size)
    else $error("fill count above window size");

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    COUNT_BITS'(write_position) < window_size)
    else $error("write position outside window");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req_take && req_word.action == ACT_CLEAR) |=>
      (held_count == '0 && running_sum == '0 && write_position == '0))
    else $error("clear left filter state behind");

  a_div_only_on_push: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_WAIT))
    else $error("divider finished outside wait step");

endmodule

@@ design/maf_divider.sv @@
`timescale 1ns / 1ps

module maf_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [maf_pkg::SUM_BITS-1:0]  dividend,
  input  logic        [maf_pkg::COUNT_BITS-1:0] divisor,
  output logic                                 done,
  output logic signed [maf_pkg::SUM_BITS-1:0]  quotient
);
  import maf_pkg::*;

  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  logic                  busy;
  logic [STEP_BITS-1:0]  steps;
  logic                  neg;
  logic [SUM_BITS-1:0]   quo;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;
  logic [SUM_BITS-1:0]   mag;

  // divide magnitudes, fix the sign afterwards: truncation toward zero
  assign mag   = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
  assign trial = {rem, quo[SUM_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_BITS'(SUM_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[SUM_BITS-1];
    end else if (busy) begin
      rem <= fits ? COUNT_BITS'(trial - {1'b0, dvs}) : trial[COUNT_BITS-1:0];
      quo <= {quo[SUM_BITS-2:0], fits};
    end
  end

  assign quotient = neg ? SUM_BITS'(-$signed(quo)) : $signed(quo);

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("divider done without a finished run");

endmodule
